FILE: sv/packed_symbol_array_store_core_defines.svh
// ----------------------------------------------------------------------------
// Packed symbol array store: assertion macros
// Shared macros for concurrent checks clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKED_SYMBOL_ARRAY_STORE_CORE_DEFINES_SVH
`define PACKED_SYMBOL_ARRAY_STORE_CORE_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSAS_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: sv/psas_pkg.sv
// ----------------------------------------------------------------------------
// Packed symbol array store: package
// Sizes, codes and the bit-field helpers shared by the store.
// ----------------------------------------------------------------------------
`default_nettype none

package psas_pkg;

	localparam int unsigned MEM_BYTES = 256;
	localparam int unsigned MEM_AW    = (MEM_BYTES > 1) ? $clog2(MEM_BYTES) : 1;
	localparam int unsigned CAP_BITS  = MEM_BYTES * 8;
	localparam int unsigned MAX_ITEMS = 2048;

	localparam int unsigned POS_W   = 11;
	localparam int unsigned COUNT_W = 12;
	localparam int unsigned SYM_W   = 8;
	localparam int unsigned ALPHA_W = 9;

	localparam int unsigned IN_W  = 24;
	localparam int unsigned OUT_W = 24;

	localparam logic REG_SYMBOL_WIDTH = 1'b0;
	localparam logic REG_ALPHABET     = 1'b1;

	typedef enum logic [1:0] {
		ACT_READ   = 2'd0,
		ACT_WRITE  = 2'd1,
		ACT_APPEND = 2'd2,
		ACT_DELETE = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_BAD_INDEX = 2'd1,
		STAT_BAD_VALUE = 2'd2,
		STAT_FULL      = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		FSM_IDLE,
		FSM_SRC_RD,
		FSM_RD_CAP,
		FSM_DST_RD,
		FSM_MERGE,
		FSM_RESP
	} fsm_t;

	function automatic logic [COUNT_W-1:0] capacity(input logic [1:0] w2);
		logic [31:0] c;
		begin
			c = 32'(CAP_BITS) >> w2;
			if (c > 32'(MAX_ITEMS))
				c = 32'(MAX_ITEMS);
			return COUNT_W'(c);
		end
	endfunction

	function automatic logic [MEM_AW-1:0] byte_addr(input logic [POS_W-1:0] pos,
			input logic [1:0] w2);
		logic [POS_W+2:0] bitpos;
		begin
			bitpos = {3'b000, pos} << w2;
			return MEM_AW'(bitpos[POS_W+2:3]);
		end
	endfunction

	function automatic logic [2:0] bit_off(input logic [POS_W-1:0] pos,
			input logic [1:0] w2);
		logic [POS_W+2:0] bitpos;
		begin
			bitpos = {3'b000, pos} << w2;
			return bitpos[2:0];
		end
	endfunction

	function automatic logic [7:0] sym_mask(input logic [1:0] w2);
		logic [3:0] w;
		logic [8:0] m;
		begin
			w = 4'd1 << w2;
			m = (9'd1 << w) - 9'd1;
			return m[7:0];
		end
	endfunction

	function automatic logic [3:0] sym_shift(input logic [1:0] w2, input logic [2:0] off);
		logic [3:0] w;
		begin
			w = 4'd1 << w2;
			return 4'd8 - w - {1'b0, off};
		end
	endfunction

	function automatic logic [7:0] sym_extract(input logic [7:0] b, input logic [1:0] w2,
			input logic [2:0] off);
		begin
			return (b >> sym_shift(w2, off)) & sym_mask(w2);
		end
	endfunction

	function automatic logic [7:0] sym_merge(input logic [7:0] b, input logic [1:0] w2,
			input logic [2:0] off, input logic [7:0] v);
		logic [7:0] m;
		logic [3:0] sh;
		begin
			sh = sym_shift(w2, off);
			m  = sym_mask(w2) << sh;
			return (b & ~m) | ((v << sh) & m);
		end
	endfunction

	function automatic logic value_ok(input logic [7:0] v, input logic [1:0] w2,
			input logic [ALPHA_W-1:0] alpha);
		logic [3:0] w;
		logic [8:0] hi;
		begin
			w  = 4'd1 << w2;
			hi = {1'b0, v} >> w;
			return ({1'b0, v} < alpha) && (hi == 9'd0);
		end
	endfunction

endpackage

`default_nettype wire

FILE: sv/packed_symbol_array_store_core.sv
// ----------------------------------------------------------------------------
// Packed symbol array store core
// Byte memory of packed 1/2/4/8-bit symbols with read, write, append, delete.
// ----------------------------------------------------------------------------
// Path from input transfer to output register: a rejected item goes straight to
// the response state; read passes source read and capture; write and append pass
// destination read and merge; delete passes source read, destination read and merge
// per moved symbol (one byte read, one byte read, one write-back per symbol step).
// A new item is taken only in the cycle after the result enters the output register.
// Reset clears the count at once; byte valid flags make all bytes read as zero.
`default_nettype none

module packed_symbol_array_store_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic                            cfg_index,
	input  wire logic [psas_pkg::ALPHA_W-1:0]    cfg_wdata,
	input  wire logic                            s_axis_tvalid,
	output logic                                 s_axis_tready,
	// action [1:0], index [12:2], value [20:13], zero [23:21]
	input  wire logic [psas_pkg::IN_W-1:0]       s_axis_tdata,
	output logic                                 m_axis_tvalid,
	input  wire logic                            m_axis_tready,
	// read_value [7:0], status [9:8], item_total [21:10], zero [23:22]
	output logic [psas_pkg::OUT_W-1:0]           m_axis_tdata
);

	psas_pkg::fsm_t                     state_q, state_d;
	logic [1:0]                         w2_q;
	logic [psas_pkg::ALPHA_W-1:0]       alpha_q;
	logic [psas_pkg::COUNT_W-1:0]       cnt_q;

	psas_pkg::action_t                  act_q;
	psas_pkg::status_t                  status_q;
	logic [psas_pkg::POS_W-1:0]         pos_q, end_q, pos_inc;
	logic [7:0]                         val_q, rd_q;

	logic [7:0]                         mem [psas_pkg::MEM_BYTES];
	logic [psas_pkg::MEM_BYTES-1:0]     vld_q;
	logic [7:0]                         rdata_q;
	logic                               mem_re, mem_we;
	logic [psas_pkg::MEM_AW-1:0]        mem_ra, mem_wa;
	logic [7:0]                         mem_wd;

	logic                               ovld_q, out_load;
	logic [7:0]                         out_rd_q;
	psas_pkg::status_t                  out_status_q;
	logic [psas_pkg::COUNT_W-1:0]       out_total_q;

	psas_pkg::action_t                  in_act;
	logic [psas_pkg::POS_W-1:0]         in_idx;
	logic [7:0]                         in_val;
	logic [psas_pkg::COUNT_W-1:0]       cap, lim;
	logic                               idx_ok, val_ok, accept;
	psas_pkg::status_t                  in_status;

	assign in_act  = psas_pkg::action_t'(s_axis_tdata[1:0]);
	assign in_idx  = s_axis_tdata[12:2];
	assign in_val  = s_axis_tdata[20:13];
	assign cap     = psas_pkg::capacity(w2_q);
	assign lim     = (cnt_q < cap) ? cnt_q : cap;
	assign idx_ok  = {1'b0, in_idx} < lim;
	assign val_ok  = psas_pkg::value_ok(in_val, w2_q, alpha_q);
	assign accept  = s_axis_tvalid && s_axis_tready;
	assign pos_inc = pos_q + psas_pkg::POS_W'(1);

	always_comb begin
		unique case (in_act)
			psas_pkg::ACT_READ, psas_pkg::ACT_DELETE: begin
				in_status = idx_ok ? psas_pkg::STAT_OK : psas_pkg::STAT_BAD_INDEX;
			end
			psas_pkg::ACT_WRITE: begin
				if (!idx_ok)
					in_status = psas_pkg::STAT_BAD_INDEX;
				else if (!val_ok)
					in_status = psas_pkg::STAT_BAD_VALUE;
				else
					in_status = psas_pkg::STAT_OK;
			end
			psas_pkg::ACT_APPEND: begin
				if (!val_ok)
					in_status = psas_pkg::STAT_BAD_VALUE;
				else if (cnt_q >= cap)
					in_status = psas_pkg::STAT_FULL;
				else
					in_status = psas_pkg::STAT_OK;
			end
			default: in_status = psas_pkg::STAT_OK;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w2_q    <= '0;
			alpha_q <= psas_pkg::ALPHA_W'(2);
		end else if (cfg_we) begin
			unique case (cfg_index)
				psas_pkg::REG_SYMBOL_WIDTH: w2_q    <= cfg_wdata[1:0];
				psas_pkg::REG_ALPHABET:     alpha_q <= cfg_wdata;
				default:                    alpha_q <= alpha_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= psas_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d       = state_q;
		s_axis_tready = 1'b0;
		mem_re        = 1'b0;
		mem_ra        = psas_pkg::byte_addr(pos_q, w2_q);
		mem_we        = 1'b0;
		mem_wa        = psas_pkg::byte_addr(pos_q, w2_q);
		mem_wd        = psas_pkg::sym_merge(rdata_q, w2_q,
			psas_pkg::bit_off(pos_q, w2_q), val_q);
		out_load      = 1'b0;
		unique case (state_q)
			psas_pkg::FSM_IDLE: begin
				s_axis_tready = 1'b1;
				if (s_axis_tvalid) begin
					if (in_status != psas_pkg::STAT_OK)
						state_d = psas_pkg::FSM_RESP;
					else if (in_act == psas_pkg::ACT_READ)
						state_d = psas_pkg::FSM_SRC_RD;
					else if (in_act == psas_pkg::ACT_DELETE &&
							{1'b0, in_idx} != lim - psas_pkg::COUNT_W'(1))
						state_d = psas_pkg::FSM_SRC_RD;
					else
						state_d = psas_pkg::FSM_DST_RD;
				end
			end
			psas_pkg::FSM_SRC_RD: begin
				mem_re = 1'b1;
				if (act_q == psas_pkg::ACT_READ) begin
					mem_ra  = psas_pkg::byte_addr(pos_q, w2_q);
					state_d = psas_pkg::FSM_RD_CAP;
				end else begin
					mem_ra  = psas_pkg::byte_addr(pos_inc, w2_q);
					state_d = psas_pkg::FSM_DST_RD;
				end
			end
			psas_pkg::FSM_RD_CAP: begin
				state_d = psas_pkg::FSM_RESP;
			end
			psas_pkg::FSM_DST_RD: begin
				mem_re  = 1'b1;
				state_d = psas_pkg::FSM_MERGE;
			end
			psas_pkg::FSM_MERGE: begin
				mem_we = 1'b1;
				if (act_q == psas_pkg::ACT_DELETE && pos_q != end_q) begin
					if (pos_inc != end_q)
						state_d = psas_pkg::FSM_SRC_RD;
					else
						state_d = psas_pkg::FSM_DST_RD;
				end else begin
					state_d = psas_pkg::FSM_RESP;
				end
			end
			psas_pkg::FSM_RESP: begin
				out_load = !ovld_q || m_axis_tready;
				if (out_load)
					state_d = psas_pkg::FSM_IDLE;
			end
			default: state_d = psas_pkg::FSM_IDLE;
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			act_q    <= in_act;
			status_q <= in_status;
			pos_q    <= (in_act == psas_pkg::ACT_APPEND) ? cnt_q[psas_pkg::POS_W-1:0] : in_idx;
			end_q    <= psas_pkg::POS_W'(lim - psas_pkg::COUNT_W'(1));
			val_q    <= (in_act == psas_pkg::ACT_DELETE) ? 8'd0 : in_val;
			rd_q     <= 8'd0;
		end else begin
			unique case (state_q)
				psas_pkg::FSM_RD_CAP: begin
					rd_q <= psas_pkg::sym_extract(rdata_q, w2_q,
						psas_pkg::bit_off(pos_q, w2_q));
				end
				psas_pkg::FSM_DST_RD: begin
					if (act_q == psas_pkg::ACT_DELETE && pos_q != end_q)
						val_q <= psas_pkg::sym_extract(rdata_q, w2_q,
							psas_pkg::bit_off(pos_inc, w2_q));
				end
				psas_pkg::FSM_MERGE: begin
					if (act_q == psas_pkg::ACT_DELETE && pos_q != end_q) begin
						pos_q <= pos_inc;
						if (pos_inc == end_q)
							val_q <= 8'd0;
					end
				end
				default: begin
					rd_q <= rd_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == psas_pkg::FSM_MERGE) begin
			if (act_q == psas_pkg::ACT_APPEND)
				cnt_q <= cnt_q + psas_pkg::COUNT_W'(1);
			else if (act_q == psas_pkg::ACT_DELETE && pos_q == end_q)
				cnt_q <= cnt_q - psas_pkg::COUNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[mem_wa] <= mem_wd;
		if (mem_re)
			rdata_q <= vld_q[mem_ra] ? mem[mem_ra] : 8'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (mem_we) begin
			vld_q[mem_wa] <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovld_q <= 1'b0;
		end else if (out_load) begin
			ovld_q <= 1'b1;
		end else if (m_axis_tready) begin
			ovld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_rd_q     <= rd_q;
			out_status_q <= status_q;
			out_total_q  <= cnt_q;
		end
	end

	assign m_axis_tvalid = ovld_q;
	assign m_axis_tdata  = {2'b00, out_total_q, out_status_q, out_rd_q};

`include "packed_symbol_array_store_core_defines.svh"

	`PSAS_ASSERT_SAME(a_no_rd_wr_overlap, mem_we, !mem_re,
		"memory read and write-back in the same cycle")
	`PSAS_ASSERT_SAME(a_delete_in_range,
		act_q == psas_pkg::ACT_DELETE && state_q != psas_pkg::FSM_IDLE &&
		state_q != psas_pkg::FSM_RESP, pos_q <= end_q,
		"delete walk passed its last position")
	`PSAS_ASSERT_SAME(a_count_bound, 1'b1,
		cnt_q <= psas_pkg::COUNT_W'(psas_pkg::MAX_ITEMS),
		"item count above the maximum")
	`PSAS_ASSERT_NEXT(a_accept_leaves_idle, accept, state_q != psas_pkg::FSM_IDLE,
		"accepted transfer did not start work")

endmodule

`default_nettype wire
